// ===== rtl/tzp_pkg.sv =====
// shared constants and types for the tensor zero-pad stream
package tzp_pkg;

   // tensor shape limits
   localparam int NUM_DIMS   = 4;
   localparam int MAX_EXTENT = 4096;
   localparam int DIM_SLOTS  = 4;

   // field widths
   localparam int SIZE_W  = 13;
   localparam int PAD_W   = 8;
   localparam int COORD_W = 13;
   localparam int EXT_W   = 14;
   localparam int DATA_W  = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;
   localparam int DIM_IDX_W  = $clog2(DIM_SLOTS);

   // register map: sizes first, then pads, one slot per dimension
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_BASE  = CSR_IDX_W'(DIM_SLOTS);
   localparam logic [CSR_IDX_W-1:0] CSR_END       = CSR_IDX_W'(2 * DIM_SLOTS);

   // reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);
   localparam logic [PAD_W-1:0]  PAD_RESET  = PAD_W'(0);

   typedef logic [SIZE_W-1:0]  size_arr_type  [DIM_SLOTS];
   typedef logic [PAD_W-1:0]   pad_arr_type   [DIM_SLOTS];
   typedef logic [COORD_W-1:0] coord_arr_type [NUM_DIMS];

endpackage

// ===== rtl/tensor_zero_pad_stream.sv =====
// tensor zero-pad stream: coordinate walker with one registered result word
// A result word appears in the cycle after its source word is accepted.
// Throughput: one word per cycle unless rsp_stall holds; the counter steps once
// per word; classification and carry over four dimensions are combinational.
// Reset: sizes return to 1, pads to 0, all coordinates to zero, output empty.
// Config writes are taken in every cycle (csr_ready tied high).
module tensor_zero_pad_stream
   import tzp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // source words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_source_value,
   // padded result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_out_value,
   output logic                  rsp_took_source,
   output logic                  rsp_last_out,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   size_arr_type  size_ff;
   pad_arr_type   pad_ff;
   coord_arr_type coord_ff, coord_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              took_ff, took_in;
   logic              last_ff, last_in;

   logic req_accept;
   logic rsp_accept;
   logic border;
   logic last_pos;

   logic [EXT_W-1:0] eff_size [NUM_DIMS];
   logic [EXT_W-1:0] half_pad [NUM_DIMS];
   logic [EXT_W-1:0] extent   [NUM_DIMS];

   // handshake: the output register frees up when its word is taken
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM_SLOTS; i++) begin
            size_ff[i] <= SIZE_RESET;
            pad_ff[i]  <= PAD_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         priority if (csr_index < CSR_PAD_BASE) begin
            size_ff[csr_index[DIM_IDX_W-1:0]] <= csr_data[SIZE_W-1:0];
         end else if (csr_index < CSR_END) begin
            pad_ff[DIM_IDX_W'(csr_index - CSR_PAD_BASE)] <= csr_data[PAD_W-1:0];
         end else begin
            // unknown index: write dropped
         end
      end
   end

   // per-dimension shape: clamped size, half pad and padded extent
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (size_ff[d] == '0) begin
            eff_size[d] = EXT_W'(1);
         end else if (EXT_W'(size_ff[d]) > EXT_W'(MAX_EXTENT)) begin
            eff_size[d] = EXT_W'(MAX_EXTENT);
         end else begin
            eff_size[d] = EXT_W'(size_ff[d]);
         end
         half_pad[d] = EXT_W'(pad_ff[d][PAD_W-1:1]);
         extent[d]   = eff_size[d] + {half_pad[d][EXT_W-2:0], 1'b0};
      end
   end

   // classify the current position and step the counter, innermost first
   always_comb begin
      logic             carry;
      logic [EXT_W-1:0] c;
      logic [EXT_W-1:0] c_next;
      border   = 1'b0;
      last_pos = 1'b1;
      carry    = 1'b1;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         c      = EXT_W'(coord_ff[d]);
         c_next = c + EXT_W'(1);
         if (c < half_pad[d] || c >= half_pad[d] + eff_size[d]) begin
            border = 1'b1;
         end
         if (c < extent[d] - EXT_W'(1)) begin
            last_pos = 1'b0;
         end
         coord_in[d] = coord_ff[d];
         if (carry && req_accept) begin
            if (c_next >= extent[d]) begin
               coord_in[d] = '0;
            end else begin
               coord_in[d] = c_next[COORD_W-1:0];
               carry       = 1'b0;
            end
         end
      end
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_value_in = out_value_ff;
      took_in      = took_ff;
      last_in      = last_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         out_value_in = border ? '0 : req_source_value;
         took_in      = !border;
         last_in      = last_pos;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            coord_ff[d] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         coord_ff     <= coord_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      took_ff      <= took_in;
      last_ff      <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_took_source = took_ff;
   assign rsp_last_out    = last_ff;

   // a border word carries zero
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !took_ff) |-> (out_value_ff == '0))
      else $error("border word with nonzero value");

   // an accepted word always lands in the output register
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word lost");

   // the final position wraps the outermost and innermost coordinates to zero
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_pos) |=> (coord_ff[0] == '0 && coord_ff[NUM_DIMS-1] == '0))
      else $error("coordinates did not wrap after last position");

   // no accept means the innermost coordinate holds
   a_coord_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> (coord_ff[NUM_DIMS-1] == $past(coord_ff[NUM_DIMS-1])))
      else $error("counter moved without an accepted word");

endmodule

// ===== test/tensor_zero_pad_stream_checker.sv =====
// checker for the tensor zero-pad stream: shape model, expected word queue and compare
module tensor_zero_pad_stream_checker
   import tzp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [DATA_W-1:0]     req_source_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DATA_W-1:0]     rsp_out_value,
   input  logic                  rsp_took_source,
   input  logic                  rsp_last_out,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    words_due
);

   localparam int HALF_DIV = 2;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              took;
      logic              last;
   } padded_word_t;

   // model copy of the shape registers and the position walker
   logic [SIZE_W-1:0]  shape_size [DIM_SLOTS];
   logic [PAD_W-1:0]   shape_pad  [DIM_SLOTS];
   logic [COORD_W-1:0] walk_coord [DIM_SLOTS];
   padded_word_t       padded_words_due [$];
   int                 mismatches;

   // zero counts as one, oversize saturates at the max extent
   function automatic int clamped_size(int d);
      int s;
      s = int'(shape_size[d]);
      if (s == 0) s = 1;
      if (s > MAX_EXTENT) s = MAX_EXTENT;
      return s;
   endfunction

   // odd pad unit is dropped
   function automatic int half_pad(int d);
      return int'(shape_pad[d]) / HALF_DIV;
   endfunction

   function automatic int padded_extent(int d);
      return clamped_size(d) + HALF_DIV * half_pad(d);
   endfunction

   // classify the current position and build the expected result word
   function automatic padded_word_t predict_padded_word(logic [DATA_W-1:0] src);
      padded_word_t w;
      logic         border;
      logic         last;
      int           c;
      int           h;
      border = 1'b0;
      last   = 1'b1;
      for (int d = 0; d < NUM_DIMS; d++) begin
         c = int'(walk_coord[d]);
         h = half_pad(d);
         if (c < h || c >= h + clamped_size(d)) border = 1'b1;
         if (c < padded_extent(d) - 1) last = 1'b0;
      end
      w.value = border ? '0 : src;
      w.took  = !border;
      w.last  = last;
      return w;
   endfunction

   always @(posedge clock) begin : watch
      padded_word_t due;
      logic         carry;
      if (reset) begin
         for (int d = 0; d < DIM_SLOTS; d++) begin
            shape_size[d] = SIZE_RESET;
            shape_pad[d]  = PAD_RESET;
            walk_coord[d] = '0;
         end
         padded_words_due.delete();
      end else begin
         // result word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (padded_words_due.size() == 0) begin
               $display("%0t: unexpected result word: expected none, actual value=%h took=%b last=%b",
                        $time, rsp_out_value, rsp_took_source, rsp_last_out);
               mismatches++;
            end else begin
               due = padded_words_due.pop_front();
               if (rsp_out_value !== due.value) begin
                  $display("%0t: out_value mismatch: expected %h actual %h",
                           $time, due.value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_took_source !== due.took) begin
                  $display("%0t: took_source mismatch: expected %b actual %b",
                           $time, due.took, rsp_took_source);
                  mismatches++;
               end
               if (rsp_last_out !== due.last) begin
                  $display("%0t: last_out mismatch: expected %b actual %b",
                           $time, due.last, rsp_last_out);
                  mismatches++;
               end
            end
         end
         // accepted source word: predict, then step the walker innermost first
         if (req_valid && !req_stall) begin
            padded_words_due.push_back(predict_padded_word(req_source_value));
            carry = 1'b1;
            for (int d = NUM_DIMS - 1; d >= 0; d--) begin
               if (carry) begin
                  if (int'(walk_coord[d]) + 1 >= padded_extent(d)) begin
                     walk_coord[d] = '0;
                  end else begin
                     walk_coord[d] = walk_coord[d] + 1'b1;
                     carry = 1'b0;
                  end
               end
            end
         end
         // register writes, unknown indexes dropped
         if (csr_valid && csr_ready) begin
            if (csr_index < CSR_PAD_BASE) begin
               shape_size[int'(csr_index - CSR_SIZE_BASE)] = csr_data[SIZE_W-1:0];
            end else if (csr_index < CSR_END) begin
               shape_pad[int'(csr_index - CSR_PAD_BASE)] = csr_data[PAD_W-1:0];
            end
         end
      end
      fail_count <= mismatches;
      words_due  <= padded_words_due.size();
   end

endmodule

// ===== test/tensor_zero_pad_stream_tb.sv =====
// testbench top for the tensor zero-pad stream: stimulus, idling and verdict
module tensor_zero_pad_stream_tb;
   import tzp_pkg::*;

   localparam int SHAPE_PHASES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_source_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_W-1:0]     rsp_out_value;
   logic                  rsp_took_source;
   logic                  rsp_last_out;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    words_due;
   logic                  no_idling = 1'b0;
   int                    stall_left = 0;

   always #5 clock = ~clock;

   tensor_zero_pad_stream u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_value (req_source_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_took_source  (rsp_took_source),
      .rsp_last_out     (rsp_last_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   tensor_zero_pad_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_value (req_source_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_took_source  (rsp_took_source),
      .rsp_last_out     (rsp_last_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .words_due        (words_due)
   );

   // result-side stall bursts of random length
   always @(posedge clock) begin
      if (reset || no_idling) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // one source word, with an optional gap ahead of it; valid stays high after
   task automatic send_word(input logic [DATA_W-1:0] value);
      int gap;
      if (!no_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_source_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait until every result word is back
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (2) @(posedge clock);
   endtask

   // one register write; valid is left high for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // all sizes and pads, sometimes an ignored write to an unknown index
   task automatic load_shape(input logic [DIM_SLOTS-1:0][CSR_DATA_W-1:0] sizes,
                             input logic [DIM_SLOTS-1:0][CSR_DATA_W-1:0] pads);
      for (int d = 0; d < DIM_SLOTS; d++) write_reg(CSR_IDX_W'(CSR_SIZE_BASE + d), sizes[d]);
      for (int d = 0; d < DIM_SLOTS; d++) write_reg(CSR_IDX_W'(CSR_PAD_BASE + d), pads[d]);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_W'(CSR_END + $urandom_range(0, 7)), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DIM_SLOTS-1:0][CSR_DATA_W-1:0] sizes;
      logic [DIM_SLOTS-1:0][CSR_DATA_W-1:0] pads;
      int words;
      int pause_at;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset shape is a single element: every word is consumed and last
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'h7F80_0000);
      drain_words();

      // zero size, pad of one adding nothing, odd pad: 1 x 1 x 4 x 3 positions
      sizes = {13'd1, 13'd2, 13'd1, 13'd0};
      pads  = {13'd3, 13'd2, 13'd0, 13'd1};
      load_shape(sizes, pads);
      for (int i = 0; i < 12; i++) send_word($urandom);
      drain_words();

      // oversize and max extents, max pads with upper data bits dropped
      sizes = {13'd1, 13'd1, 13'd4096, 13'd8191};
      pads  = {13'd0, 13'd0, 13'h1FFF, 13'd254};
      load_shape(sizes, pads);
      for (int i = 0; i < 6; i++) send_word($urandom);
      drain_words();

      // random shapes; the walker carries its position across each reshape
      for (int p = 0; p < SHAPE_PHASES; p++) begin
         no_idling <= (p == SHAPE_PHASES - 1) || ($urandom_range(0, 3) == 0);
         for (int d = 0; d < DIM_SLOTS; d++) begin
            case ((p < 2) ? 9 : $urandom_range(0, 9))
               0:       sizes[d] = CSR_DATA_W'(MAX_EXTENT);
               1:       sizes[d] = CSR_DATA_W'($urandom_range(MAX_EXTENT + 1, 8191));
               2:       sizes[d] = '0;
               default: sizes[d] = CSR_DATA_W'((d < 2) ? $urandom_range(1, 2)
                                                      : $urandom_range(1, 5));
            endcase
            case ((p < 2) ? 9 : $urandom_range(0, 9))
               0:       pads[d] = CSR_DATA_W'($urandom_range(250, 255));
               1:       pads[d] = CSR_DATA_W'($urandom_range(0, 8191));
               default: pads[d] = CSR_DATA_W'((d < 2) ? $urandom_range(0, 2)
                                                     : $urandom_range(0, 4));
            endcase
         end
         load_shape(sizes, pads);
         words    = $urandom_range(40, 60);
         pause_at = $urandom_range(5, words - 5);
         for (int i = 0; i < words; i++) begin
            // hold off until the block has handed back everything
            if (i == pause_at) drain_words();
            send_word($urandom);
         end
         drain_words();
      end

      repeat (5) @(posedge clock);
      if (fail_count == 0 && words_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tzp_pkg.sv
rtl/tensor_zero_pad_stream.sv
test/tensor_zero_pad_stream_checker.sv
test/tensor_zero_pad_stream_tb.sv
